@@ hdl/x86_16_subset_execute_core_assert.svh @@
// Assertion macros for the execute core. Define ASSERT_OFF to compile them out.
`ifndef X86_16_SUBSET_EXECUTE_CORE_ASSERT_SVH
`define X86_16_SUBSET_EXECUTE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset.
`define X86EC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define X86EC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define X86EC_ASSERT(name, prop, msg)
`define X86EC_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

@@ hdl/x86ec_pkg.sv @@
package x86ec_pkg;

  // Operation kind reported with each result.
  typedef enum logic [2:0] {
    KIND_MOV     = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_SUB     = 3'd2,
    KIND_CMP     = 3'd3,
    KIND_JNZ     = 3'd4,
    KIND_JMP_NOP = 3'd5,
    KIND_UNKNOWN = 3'd6
  } kind_t;

  // Eight 16-bit general registers, ax..di.
  typedef logic [7:0][15:0] regfile_t;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;

  // mod field codes
  localparam logic [1:0] MOD_NODISP = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP16 = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;

  // rm code that means a direct 16-bit address when mod is zero
  localparam logic [2:0] RM_DIRECT = 3'b110;

  // ALU group codes, both in opcode bits 5:3 and in the group-immediate reg field
  localparam logic [2:0] GRP_ADD = 3'b000;
  localparam logic [2:0] GRP_SUB = 3'b101;
  localparam logic [2:0] GRP_CMP = 3'b111;

  // Low three opcode bits of the ALU rows: below ALU_FORM_ACC are the mod/rm
  // forms, from there up to ALU_FORM_LIMIT the accumulator-immediate forms.
  localparam logic [2:0] ALU_FORM_ACC   = 3'd4;
  localparam logic [2:0] ALU_FORM_LIMIT = 3'd6;

  // Opcode patterns of the supported forms, compared after masking off the
  // d, s, w and register bits.
  localparam logic [7:0] OP_MOV_RM      = 8'h88;  // 88..8B, mask FC
  localparam logic [7:0] OP_MOV_IMM_RM  = 8'hC6;  // C6..C7, mask FE
  localparam logic [7:0] OP_MOV_IMM_REG = 8'hB0;  // B0..BF, mask F0
  localparam logic [7:0] OP_GRP_IMM     = 8'h80;  // 80..83, mask FC
  localparam logic [7:0] OP_JCC         = 8'h70;  // 70..7F, mask F0
  localparam logic [7:0] OP_LOOP        = 8'hE0;  // E0..E3, mask FC

  localparam logic [7:0] OP_JNZ = 8'h75;
  localparam logic [2:0] REG_AX = 3'd0;

  // Reads a register at word or byte width. Byte numbers 0..3 are the low
  // halves of ax..bx, 4..7 the high halves.
  function automatic logic [15:0] read_reg(input regfile_t rf, input logic [2:0] idx,
                                           input logic w);
    logic [15:0] full;
    full = rf[{1'b0, idx[1:0]}];
    if (w) begin
      return rf[idx];
    end else if (idx[2]) begin
      return {8'h00, full[15:8]};
    end else begin
      return {8'h00, full[7:0]};
    end
  endfunction

endpackage

@@ hdl/x86_16_subset_execute_core.sv @@
// A request is held in the input register, then executed into the output register.
// Throughput: one instruction per cycle while the output side keeps draining, set by
// the single execute stage that reads and updates the register file, flags and ip in
// the same cycle.
// Reset (rst_n low, synchronous): all registers, flags and ip cleared, both stages emptied.
`include "x86_16_subset_execute_core_assert.svh"

module x86_16_subset_execute_core
  import x86ec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // opcode_byte[7:0], modrm_byte[15:8], third_byte[23:16],
  // fourth_byte[31:24], fifth_byte[39:32], sixth_byte[47:40]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // length[2:0], next_ip[18:3], reg_written[19], reg_index[22:20], wide[23],
  // reg_value[39:24], zero_flag[40], sign_flag[41], zero fill[47:42]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind[2:0]
  output logic [OUT_USER_W-1:0] out_tuser
);

  // ---------------------------------------------------------------------------
  // Input stage. The request register is refilled in the same cycle that its
  // instruction moves on to execute, so a new request can arrive every cycle
  // as long as the output side keeps draining.
  // ---------------------------------------------------------------------------
  logic                 in_v_r;
  logic [IN_DATA_W-1:0] in_data_r;
  logic                 out_v_r;
  logic                 in_fire;
  logic                 exec_fire;

  // Execute runs when an instruction is held and the output register is free
  // or being emptied in this same cycle.
  assign exec_fire = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || exec_fire;
  assign in_fire   = in_tvalid && in_tready;

  // Architectural state.
  regfile_t    rf_r;
  logic        zf_r;
  logic        sf_r;
  logic [15:0] ip_r;

  // ---------------------------------------------------------------------------
  // Decode. Picks the operation, the width, the length, and the destination
  // and source operand of the single ALU operation (if any).
  // ---------------------------------------------------------------------------
  logic [7:0]  op, b1, b2, b3, b4, b5;
  logic [1:0]  mod;
  logic [2:0]  regf, rm;
  logic [1:0]  dl;
  logic [7:0]  imm_lo, imm_hi;
  kind_t       dec_kind;
  logic [2:0]  dec_len;
  logic        dec_w;
  logic        do_apply;
  logic [2:0]  dst;
  logic [15:0] src;

  always_comb begin
    op   = in_data_r[7:0];
    b1   = in_data_r[15:8];
    b2   = in_data_r[23:16];
    b3   = in_data_r[31:24];
    b4   = in_data_r[39:32];
    b5   = in_data_r[47:40];
    mod  = b1[7:6];
    regf = b1[5:3];
    rm   = b1[2:0];

    // Displacement bytes that follow the mod/rm byte.
    case (mod)
      MOD_NODISP: dl = (rm == RM_DIRECT) ? 2'd2 : 2'd0;
      MOD_DISP8:  dl = 2'd1;
      MOD_DISP16: dl = 2'd2;
      default:    dl = 2'd0;
    endcase

    // The immediate of the r/m forms starts right after the displacement.
    case (dl)
      2'd0: begin
        imm_lo = b2;
        imm_hi = b3;
      end
      2'd1: begin
        imm_lo = b3;
        imm_hi = b4;
      end
      default: begin
        imm_lo = b4;
        imm_hi = b5;
      end
    endcase

    dec_kind = KIND_UNKNOWN;
    dec_len  = 3'd2;
    dec_w    = 1'b0;
    do_apply = 1'b0;
    dst      = REG_AX;
    src      = 16'h0000;

    if (op[7:2] == OP_MOV_RM[7:2]) begin
      // mov between register and r/m; d bit picks the direction.
      dec_kind = KIND_MOV;
      dec_w    = op[0];
      dec_len  = 3'd2 + {1'b0, dl};
      if (mod == MOD_REG) begin
        do_apply = 1'b1;
        dst      = op[1] ? regf : rm;
        src      = read_reg(rf_r, op[1] ? rm : regf, op[0]);
      end
    end else if (op[7:1] == OP_MOV_IMM_RM[7:1]) begin
      // mov immediate to r/m; the reg field is ignored.
      dec_kind = KIND_MOV;
      dec_w    = op[0];
      dec_len  = 3'd2 + {1'b0, dl} + (op[0] ? 3'd2 : 3'd1);
      src      = op[0] ? {imm_hi, imm_lo} : {8'h00, imm_lo};
      if (mod == MOD_REG) begin
        do_apply = 1'b1;
        dst      = rm;
      end
    end else if (op[7:4] == OP_MOV_IMM_REG[7:4]) begin
      // mov immediate to register, register number in the opcode.
      dec_kind = KIND_MOV;
      dec_w    = op[3];
      dec_len  = op[3] ? 3'd3 : 3'd2;
      src      = op[3] ? {b2, b1} : {8'h00, b1};
      do_apply = 1'b1;
      dst      = op[2:0];
    end else if (op[7:6] == 2'b00 && op[2:0] < ALU_FORM_LIMIT &&
                 (op[5:3] == GRP_ADD || op[5:3] == GRP_SUB || op[5:3] == GRP_CMP)) begin
      // add/sub/cmp, register forms and accumulator-immediate forms.
      case (op[5:3])
        GRP_ADD: dec_kind = KIND_ADD;
        GRP_SUB: dec_kind = KIND_SUB;
        default: dec_kind = KIND_CMP;
      endcase
      dec_w = op[0];
      if (op[2:0] < ALU_FORM_ACC) begin
        dec_len = 3'd2 + {1'b0, dl};
        if (mod == MOD_REG) begin
          do_apply = 1'b1;
          dst      = op[1] ? regf : rm;
          src      = read_reg(rf_r, op[1] ? rm : regf, op[0]);
        end
      end else begin
        dec_len  = op[0] ? 3'd3 : 3'd2;
        src      = op[0] ? {b2, b1} : {8'h00, b1};
        do_apply = 1'b1;
        dst      = REG_AX;
      end
    end else if (op[7:2] == OP_GRP_IMM[7:2]) begin
      // Group immediate. With s set on a word form the byte immediate is
      // sign-extended; on a byte form s changes nothing.
      dec_w = op[0];
      if (op[0] && !op[1]) begin
        dec_len = 3'd4 + {1'b0, dl};
        src     = {imm_hi, imm_lo};
      end else begin
        dec_len = 3'd3 + {1'b0, dl};
        src     = (op[0] && imm_lo[7]) ? {8'hFF, imm_lo} : {8'h00, imm_lo};
      end
      case (regf)
        GRP_ADD: dec_kind = KIND_ADD;
        GRP_SUB: dec_kind = KIND_SUB;
        GRP_CMP: dec_kind = KIND_CMP;
        default: begin
          dec_kind = KIND_UNKNOWN;
          dec_w    = 1'b0;
        end
      endcase
      if (dec_kind != KIND_UNKNOWN && mod == MOD_REG) begin
        do_apply = 1'b1;
        dst      = rm;
      end
    end else if (op == OP_JNZ) begin
      dec_kind = KIND_JNZ;
    end else if (op[7:4] == OP_JCC[7:4] || op[7:2] == OP_LOOP[7:2]) begin
      // Other conditional jumps and the loop family pass as two-byte no-ops.
      dec_kind = KIND_JMP_NOP;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute: one adder/subtractor at the operation width, flag generation,
  // register merge for byte writes, and the next instruction pointer.
  // ---------------------------------------------------------------------------
  logic [15:0] a_val;
  logic [15:0] sum;
  logic [15:0] res;
  logic        res_zf;
  logic        res_sf;
  logic        upd_flags;
  logic        do_write;
  logic [2:0]  wr_row;
  logic [15:0] old_row;
  logic [15:0] new_row;
  logic [15:0] next_ip;

  always_comb begin
    a_val = read_reg(rf_r, dst, dec_w);
    sum   = (dec_kind == KIND_ADD) ? a_val + src : a_val - src;
    res   = (dec_kind == KIND_MOV) ? src : sum;
    if (!dec_w) begin
      res = {8'h00, res[7:0]};
    end
    res_zf    = (res == 16'h0000);
    res_sf    = dec_w ? res[15] : res[7];
    upd_flags = do_apply && dec_kind != KIND_MOV;
    do_write  = do_apply && dec_kind != KIND_CMP;

    // A byte register lives in one half of ax..bx.
    wr_row  = dec_w ? dst : {1'b0, dst[1:0]};
    old_row = rf_r[wr_row];
    if (dec_w) begin
      new_row = res;
    end else if (dst[2]) begin
      new_row = {res[7:0], old_row[7:0]};
    end else begin
      new_row = {old_row[15:8], res[7:0]};
    end

    // jnz is taken on the flags left by the previous instruction.
    if (dec_kind == KIND_JNZ && !zf_r) begin
      next_ip = ip_r + 16'd2 + {{8{b1[7]}}, b1};
    end else begin
      next_ip = ip_r + {13'd0, dec_len};
    end
  end

  // ---------------------------------------------------------------------------
  // Output register fields.
  // ---------------------------------------------------------------------------
  logic [2:0]  out_len_r;
  logic [15:0] out_ip_r;
  kind_t       out_kind_r;
  logic        out_written_r;
  logic [2:0]  out_idx_r;
  logic        out_w_r;
  logic [15:0] out_val_r;
  logic        out_zf_r;
  logic        out_sf_r;

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      rf_r    <= '0;
      zf_r    <= 1'b0;
      sf_r    <= 1'b0;
      ip_r    <= 16'h0000;
    end else begin
      if (in_fire) begin
        in_v_r <= 1'b1;
      end else if (exec_fire) begin
        in_v_r <= 1'b0;
      end
      if (exec_fire) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (exec_fire) begin
        ip_r <= next_ip;
        if (upd_flags) begin
          zf_r <= res_zf;
          sf_r <= res_sf;
        end
        if (do_write) begin
          rf_r[wr_row] <= new_row;
        end
      end
    end
  end

  // Payload registers; qualified by the valid bits above.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= in_tdata;
    end
    if (exec_fire) begin
      out_len_r     <= dec_len;
      out_ip_r      <= next_ip;
      out_kind_r    <= dec_kind;
      out_written_r <= do_write;
      out_idx_r     <= do_write ? dst : REG_AX;
      out_w_r       <= dec_w;
      out_val_r     <= do_write ? new_row : 16'h0000;
      out_zf_r      <= upd_flags ? res_zf : zf_r;
      out_sf_r      <= upd_flags ? res_sf : sf_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_sf_r, out_zf_r, out_val_r, out_w_r, out_idx_r,
                       out_written_r, out_ip_r, out_len_r};
  assign out_tuser  = out_kind_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `X86EC_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !in_v_r && !out_v_r,
    "pipeline not empty after reset")
  `X86EC_ASSERT(a_cmp_no_write, out_v_r && out_kind_r == KIND_CMP |-> !out_written_r,
    "cmp reported a register write")
  `X86EC_ASSERT(a_mov_keeps_flags,
    exec_fire && dec_kind == KIND_MOV |=> zf_r == $past(zf_r) && sf_r == $past(sf_r),
    "mov changed the flags")
  `X86EC_ASSERT(a_jnz_not_taken,
    exec_fire && dec_kind == KIND_JNZ && zf_r |=> ip_r == $past(ip_r) + 16'd2,
    "jnz with zero flag set did not fall through")

endmodule
